@@ rtl/pcsa_pkg.sv @@
// ----------------------------------------------------------------------------
// pcsa_pkg
// Shared constants, register indexes and types of the saturation adjust block.
// ----------------------------------------------------------------------------
package pcsa_pkg;

    localparam int SampleW  = 16;
    localparam int ChGainW  = 10;
    localparam int GlbGainW = 11;
    localparam int BitsW    = 5;
    localparam int GainW    = ChGainW + GlbGainW;   // Q5.16 product
    localparam int LumaW    = 32;                   // Q16.16 luma
    localparam int CgW      = SampleW + GainW;      // sample times gain
    localparam int LgW      = LumaW + GainW;        // luma times gain
    localparam int AccW     = 56;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 11;
    localparam int NumCh    = 3;

    localparam logic [15:0] LumaWr = 16'd19595;
    localparam logic [15:0] LumaWg = 16'd38470;
    localparam logic [15:0] LumaWb = 16'd7471;

    localparam logic [ChGainW-1:0]  GainLimit    = 10'd768;
    localparam logic [ChGainW-1:0]  ChGainReset  = 10'd256;
    localparam logic [GlbGainW-1:0] GlbGainReset = 11'd256;
    localparam logic [BitsW-1:0]    BitsReset    = 5'd8;
    localparam logic [BitsW-1:0]    BitsMin      = 5'd1;
    localparam logic [BitsW-1:0]    BitsMax      = 5'd16;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RED_GAIN    = 3'd0,
        CFG_GREEN_GAIN  = 3'd1,
        CFG_BLUE_GAIN   = 3'd2,
        CFG_GLOBAL_GAIN = 3'd3,
        CFG_SAMPLE_BITS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [NumCh-1:0][GainW-1:0] gain;
        logic [SampleW-1:0]          maxv;
    } t_cfg;

endpackage

@@ rtl/pcsa_in_if.sv @@
// ----------------------------------------------------------------------------
// pcsa_in_if
// Input pixel channel: valid/ready handshake with one RGB sample triple.
// ----------------------------------------------------------------------------
interface pcsa_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

@@ rtl/pcsa_out_if.sv @@
// ----------------------------------------------------------------------------
// pcsa_out_if
// Output pixel channel: valid/ready handshake with one adjusted RGB triple.
// ----------------------------------------------------------------------------
interface pcsa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

@@ rtl/pcsa_cfg.sv @@
// ----------------------------------------------------------------------------
// pcsa_cfg
// Configuration registers; derives the per-channel gains and sample maximum.
// ----------------------------------------------------------------------------
module pcsa_cfg
    import pcsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    logic [NumCh-1:0][ChGainW-1:0] r_ch_gain;
    logic [GlbGainW-1:0]           r_glb_gain;
    logic [BitsW-1:0]              r_bits;

    logic [ChGainW-1:0]            lim_gain;
    logic [BitsW-1:0]              bits_eff;
    logic [BitsW-1:0]              shift_amt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_gain  <= {NumCh{ChGainReset}};
            r_glb_gain <= GlbGainReset;
            r_bits     <= BitsReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RED_GAIN:    r_ch_gain[0] <= i_cfg_data[ChGainW-1:0];
                CFG_GREEN_GAIN:  r_ch_gain[1] <= i_cfg_data[ChGainW-1:0];
                CFG_BLUE_GAIN:   r_ch_gain[2] <= i_cfg_data[ChGainW-1:0];
                CFG_GLOBAL_GAIN: r_glb_gain   <= i_cfg_data[GlbGainW-1:0];
                CFG_SAMPLE_BITS: r_bits       <= i_cfg_data[BitsW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lim_gain = '0;
        for (int i = 0; i < NumCh; i++) begin
            lim_gain = (r_ch_gain[i] > GainLimit) ? GainLimit : r_ch_gain[i];
            o_cfg.gain[i] = GainW'(lim_gain) * GainW'(r_glb_gain);
        end
        if (r_bits < BitsMin) begin
            bits_eff = BitsMin;
        end else if (r_bits > BitsMax) begin
            bits_eff = BitsMax;
        end else begin
            bits_eff = r_bits;
        end
        shift_amt  = BitsMax - bits_eff;
        o_cfg.maxv = {SampleW{1'b1}} >> shift_amt;
    end

endmodule

@@ rtl/pcsa_pipe.sv @@
// ----------------------------------------------------------------------------
// pcsa_pipe
// Four-stage datapath: clip, luma and sample products, luma products, mix.
// ----------------------------------------------------------------------------
module pcsa_pipe
    import pcsa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    pcsa_in_if.sink    i_pix,
    pcsa_out_if.source o_pix
);

    typedef struct packed {
        logic [NumCh-1:0][SampleW-1:0] smp;
        logic [NumCh-1:0][GainW-1:0]   gain;
        logic [SampleW-1:0]            maxv;
    } t_s1;

    typedef struct packed {
        logic [LumaW-1:0]              luma;
        logic [NumCh-1:0][CgW-1:0]     cg;
        logic [NumCh-1:0][GainW-1:0]   gain;
        logic [SampleW-1:0]            maxv;
    } t_s2;

    typedef struct packed {
        logic [LumaW-1:0]              luma;
        logic [NumCh-1:0][CgW-1:0]     cg;
        logic [NumCh-1:0][LgW-1:0]     lg;
        logic [SampleW-1:0]            maxv;
    } t_s3;

    logic r_v1, r_v2, r_v3, r_v4;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    logic [NumCh-1:0][SampleW-1:0] r_out, n_out;

    logic en1, en2, en3, en4;
    logic [NumCh-1:0][SampleW-1:0] raw;
    logic [NumCh-1:0][AccW-1:0]    acc;

    assign en4 = !r_v4 || o_pix.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_pix.ready = en1;
    assign o_pix.valid = r_v4;
    assign o_pix.red_out   = r_out[0];
    assign o_pix.green_out = r_out[1];
    assign o_pix.blue_out  = r_out[2];

    assign raw[0] = i_pix.red_in;
    assign raw[1] = i_pix.green_in;
    assign raw[2] = i_pix.blue_in;

    always_comb begin
        for (int i = 0; i < NumCh; i++) begin
            n_s1.smp[i] = (raw[i] > i_cfg.maxv) ? i_cfg.maxv : raw[i];
        end
        n_s1.gain = i_cfg.gain;
        n_s1.maxv = i_cfg.maxv;
    end

    always_comb begin
        n_s2.luma = LumaW'(r_s1.smp[0]) * LumaW'(LumaWr)
                  + LumaW'(r_s1.smp[1]) * LumaW'(LumaWg)
                  + LumaW'(r_s1.smp[2]) * LumaW'(LumaWb);
        for (int i = 0; i < NumCh; i++) begin
            n_s2.cg[i] = CgW'(r_s1.smp[i]) * CgW'(r_s1.gain[i]);
        end
        n_s2.gain = r_s1.gain;
        n_s2.maxv = r_s1.maxv;
    end

    always_comb begin
        for (int i = 0; i < NumCh; i++) begin
            n_s3.lg[i] = LgW'(r_s2.luma) * LgW'(r_s2.gain[i]);
        end
        n_s3.luma = r_s2.luma;
        n_s3.cg   = r_s2.cg;
        n_s3.maxv = r_s2.maxv;
    end

    always_comb begin
        for (int i = 0; i < NumCh; i++) begin
            acc[i] = (AccW'(r_s3.luma) << 16)
                   + (AccW'(r_s3.cg[i]) << 16)
                   - AccW'(r_s3.lg[i])
                   + (AccW'(1) << 31);
            if (acc[i][AccW-1]) begin
                n_out[i] = '0;
            end else if (acc[i][AccW-2:32] > (AccW-33)'(r_s3.maxv)) begin
                n_out[i] = r_s3.maxv;
            end else begin
                n_out[i] = acc[i][47:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_pix.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1  <= n_s1;
        if (en2) r_s2  <= n_s2;
        if (en3) r_s3  <= n_s3;
        if (en4) r_out <= n_out;
    end

endmodule

@@ rtl/per_channel_saturation_adjust.sv @@
// ----------------------------------------------------------------------------
// per_channel_saturation_adjust
// Luma-based per-channel saturation adjust of an RGB pixel stream.
// ----------------------------------------------------------------------------
// One pixel is taken every clock while the input is ready, and each pixel
// passes through a four-stage pipeline: sample clipping, luma and
// sample-by-gain products, luma-by-gain products, then mix, rounding and
// clamping. Each stage holds only while its successor is full and stalled, so
// bubbles close up and a stall on the output side reaches the input only once
// all four stages hold a pixel. Register writes apply to every pixel taken
// from the next clock on; write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module per_channel_saturation_adjust
    import pcsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    pcsa_in_if.sink             i_pix,
    pcsa_out_if.source          o_pix
);

    t_cfg cfg;

    pcsa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pcsa_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .o_pix   (o_pix)
    );

endmodule
